>>> src/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Same, with the consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> src/cbpg_pkg.sv
// ----------------------------------------------------------------------------
// cbpg_pkg
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cbpg_pkg;

   localparam int IN_COORD_W     = 15;
   localparam int STEPS_W        = 6;
   localparam int REQ_DATA_W     = 128;
   localparam int RSP_DATA_W     = 32;
   localparam int MAX_STEPS_DEF  = 63;
   localparam int COORD_BITS_DEF = 15;

   typedef struct packed {
      logic       load;
      logic       pow;
      logic       cube;
      logic       mac;
      logic [1:0] mac_sel;
      logic       div_init;
      logic       div_step;
      logic       advance;
   } cmd_type;

   typedef struct packed {
      logic last;
   } status_type;

endpackage

>>> src/cbpg_datapath.sv
// ----------------------------------------------------------------------------
// cbpg_datapath
// Weight, multiply-accumulate and restoring-divide datapath for one point.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cbpg_datapath #(
   parameter int MAX_STEPS  = cbpg_pkg::MAX_STEPS_DEF,
   parameter int COORD_BITS = cbpg_pkg::COORD_BITS_DEF
) (
   input  logic                                  clock,
   input  cbpg_pkg::cmd_type                     cmd,
   input  logic [7:0][cbpg_pkg::IN_COORD_W-1:0]  coords,
   input  logic [cbpg_pkg::STEPS_W-1:0]          step_count,
   output cbpg_pkg::status_type                  status,
   output logic [COORD_BITS-1:0]                 point_x,
   output logic [COORD_BITS-1:0]                 point_y
);

   localparam int SW    = $clog2(MAX_STEPS + 1);
   localparam int ACC_W = COORD_BITS + 3 * SW;

   logic [3:0][COORD_BITS-1:0] cx_ff, cy_ff;
   logic [SW-1:0]              n_ff, k_ff, m;
   logic [2*SW-1:0]            m2_ff, k2_ff, n2_ff;
   logic [3:0][3*SW-1:0]       w_ff;
   logic [3*SW-1:0]            n3_ff, t1, t2, t3;
   logic [ACC_W-1:0]           accx_ff, accy_ff, remx_ff, remy_ff, dsh_ff;
   logic [ACC_W-1:0]           prodx, prody;
   logic [COORD_BITS-1:0]      qx_ff, qy_ff;
   logic [SW-1:0]              n_in;
   logic                       gex, gey;

   localparam logic [cbpg_pkg::STEPS_W-1:0] MAX_N = cbpg_pkg::STEPS_W'(MAX_STEPS);

   always_comb begin
      if (step_count == '0) begin
         n_in = SW'(1);
      end else if (step_count > MAX_N) begin
         n_in = SW'(MAX_STEPS);
      end else begin
         n_in = SW'(step_count);
      end
   end

   assign m     = n_ff - k_ff;
   assign t1    = (3*SW)'(m2_ff) * (3*SW)'(m);
   assign t2    = (3*SW)'(k2_ff) * (3*SW)'(m);
   assign t3    = (3*SW)'(m2_ff) * (3*SW)'(k_ff);
   assign prodx = ACC_W'(cx_ff[cmd.mac_sel]) * ACC_W'(w_ff[cmd.mac_sel]);
   assign prody = ACC_W'(cy_ff[cmd.mac_sel]) * ACC_W'(w_ff[cmd.mac_sel]);
   assign gex   = remx_ff >= dsh_ff;
   assign gey   = remy_ff >= dsh_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int i = 0; i < 4; i++) begin
            cx_ff[i] <= COORD_BITS'(coords[2*i]);
            cy_ff[i] <= COORD_BITS'(coords[2*i+1]);
         end
         n_ff <= n_in;
         k_ff <= '0;
      end
      if (cmd.advance) begin
         k_ff <= k_ff + SW'(1);
      end
      if (cmd.pow) begin
         m2_ff   <= (2*SW)'(m) * (2*SW)'(m);
         k2_ff   <= (2*SW)'(k_ff) * (2*SW)'(k_ff);
         n2_ff   <= (2*SW)'(n_ff) * (2*SW)'(n_ff);
         accx_ff <= '0;
         accy_ff <= '0;
      end
      if (cmd.cube) begin
         // weights: m^3, 3km^2, 3k^2m, k^3 (each at most n^3)
         w_ff[0] <= t1;
         w_ff[1] <= (t3 << 1) + t3;
         w_ff[2] <= (t2 << 1) + t2;
         w_ff[3] <= (3*SW)'(k2_ff) * (3*SW)'(k_ff);
         n3_ff   <= (3*SW)'(n2_ff) * (3*SW)'(n_ff);
      end
      if (cmd.mac) begin
         accx_ff <= accx_ff + prodx;
         accy_ff <= accy_ff + prody;
      end
      if (cmd.div_init) begin
         remx_ff <= accx_ff;
         remy_ff <= accy_ff;
         dsh_ff  <= ACC_W'(n3_ff) << (COORD_BITS - 1);
         qx_ff   <= '0;
         qy_ff   <= '0;
      end
      if (cmd.div_step) begin
         remx_ff <= gex ? remx_ff - dsh_ff : remx_ff;
         remy_ff <= gey ? remy_ff - dsh_ff : remy_ff;
         qx_ff   <= {qx_ff[COORD_BITS-2:0], gex};
         qy_ff   <= {qy_ff[COORD_BITS-2:0], gey};
         dsh_ff  <= dsh_ff >> 1;
      end
   end

   assign status.last = (k_ff == n_ff);
   assign point_x     = qx_ff;
   assign point_y     = qy_ff;

endmodule

>>> src/cbpg_ctrl.sv
// ----------------------------------------------------------------------------
// cbpg_ctrl
// Sequencer: per point runs powers, weights, 4 MAC steps, divide, output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cbpg_ctrl #(
   parameter int COORD_BITS = cbpg_pkg::COORD_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  cbpg_pkg::status_type status,
   output cbpg_pkg::cmd_type    cmd
);

   localparam int CNT_W = $clog2(COORD_BITS);

   typedef enum logic [2:0] {
      IDLE, POW, CUBE, MAC, DINIT, DIV, OUT
   } state_type;

   state_type        state_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             req_tready_ff, rsp_tvalid_ff;

   assign req_tready = req_tready_ff;
   assign rsp_tvalid = rsp_tvalid_ff;

   always_comb begin
      cmd          = '0;
      cmd.load     = req_tvalid & req_tready_ff;
      cmd.pow      = (state_ff == POW);
      cmd.cube     = (state_ff == CUBE);
      cmd.mac      = (state_ff == MAC);
      cmd.mac_sel  = cnt_ff[1:0];
      cmd.div_init = (state_ff == DINIT);
      cmd.div_step = (state_ff == DIV);
      cmd.advance  = (state_ff == OUT) & rsp_tready & ~status.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         cnt_ff        <= '0;
         req_tready_ff <= 1'b1;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            IDLE: begin
               if (req_tvalid) begin
                  state_ff      <= POW;
                  req_tready_ff <= 1'b0;
               end
            end
            POW: state_ff <= CUBE;
            CUBE: begin
               state_ff <= MAC;
               cnt_ff   <= '0;
            end
            MAC: begin
               cnt_ff <= cnt_ff + CNT_W'(1);
               if (cnt_ff[1:0] == 2'd3) begin
                  state_ff <= DINIT;
               end
            end
            DINIT: begin
               state_ff <= DIV;
               cnt_ff   <= '0;
            end
            DIV: begin
               cnt_ff <= cnt_ff + CNT_W'(1);
               if (cnt_ff == CNT_W'(COORD_BITS - 1)) begin
                  state_ff      <= OUT;
                  rsp_tvalid_ff <= 1'b1;
               end
            end
            OUT: begin
               if (rsp_tready) begin
                  rsp_tvalid_ff <= 1'b0;
                  if (status.last) begin
                     state_ff      <= IDLE;
                     req_tready_ff <= 1'b1;
                  end else begin
                     state_ff <= POW;
                  end
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

endmodule

>>> src/cubic_bezier_point_generator.sv
// ----------------------------------------------------------------------------
// cubic_bezier_point_generator
// Emits n+1 exact integer points of a cubic Bezier curve per request.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one transaction carries four control points and a step
//   count n (0 is taken as 1, above MAX_STEPS saturates to MAX_STEPS).
//   rsp channel: n+1 transactions follow, point k = 0..n, each coordinate
//   floor(sum of Bernstein weights * control / n^3); tlast marks k = n.
//   Each point runs powers, weights, four multiply-accumulate steps and
//   a restoring divide that resolves one quotient bit per cycle.
//   One request is worked at a time: req_tready is high only while idle,
//   so a request occupies the block until its last point is taken.
//   A stalled receiver holds the point in the output register; work
//   resumes on the next point once it is taken.
//   Reset (synchronous, active high) returns to idle with req_tready high
//   and rsp_tvalid low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cubic_bezier_point_generator #(
   parameter int MAX_STEPS  = cbpg_pkg::MAX_STEPS_DEF,
   parameter int COORD_BITS = cbpg_pkg::COORD_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y (15 b each), step count (6 b)
   input  logic [cbpg_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // point_x (15 b), point_y (15 b)
   output logic [cbpg_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast
);

   localparam int CW = cbpg_pkg::IN_COORD_W;

   cbpg_pkg::cmd_type              cmd;
   cbpg_pkg::status_type           status;
   logic [7:0][CW-1:0]             coords;
   logic [COORD_BITS-1:0]          point_x, point_y;

   // unpack the eight coordinates, lowest field first
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         coords[i] = req_tdata[i*CW +: CW];
      end
   end

   cbpg_ctrl #(
      .COORD_BITS (COORD_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   cbpg_datapath #(
      .MAX_STEPS  (MAX_STEPS),
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock      (clock),
      .cmd        (cmd),
      .coords     (coords),
      .step_count (req_tdata[8*CW +: cbpg_pkg::STEPS_W]),
      .status     (status),
      .point_x    (point_x),
      .point_y    (point_y)
   );

   assign rsp_tdata = {{(cbpg_pkg::RSP_DATA_W - 2*CW){1'b0}}, CW'(point_y), CW'(point_x)};
   assign rsp_tlast = status.last;

endmodule

>>> src/cbpg_checker.sv
// ----------------------------------------------------------------------------
// cbpg_checker
// Port-level checks of the point generator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cbpg_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [cbpg_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast
);

   // a request closes the input until its last point goes out
   `ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready)
   // never accepting while a point is pending
   `ASSERT_IMPL(a_one_at_a_time, clock, reset, req_tready, !rsp_tvalid)
   // after the final point the output goes quiet
   `ASSERT_NEXT(a_quiet_after_last, clock, reset,
                rsp_tvalid && rsp_tready && rsp_tlast, !rsp_tvalid)
   // stalled point holds
   `ASSERT_NEXT(a_hold_stalled, clock, reset, rsp_tvalid && !rsp_tready,
                rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

endmodule

bind cubic_bezier_point_generator cbpg_checker u_cbpg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
